### hdl/assert_macros.svh
// Assertion macros shared by the hash map RTL.
// Relies on each including module having i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LPHM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LPHM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lphm_pkg.sv
// Shared types and codes for the linear probing hash map.
// No dependencies; imported by the top level, lphm_ctrl and lphm_dp.
`timescale 1ns / 1ps
`default_nettype none

package lphm_pkg;

    localparam int KEY_W    = 64;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 2;

    // The home slot is reduced one DIGIT_W-bit key digit at a time.
    localparam int DIGIT_W    = 16;
    localparam int HASH_STEPS = 2 * (KEY_W / DIGIT_W);
    localparam int HASH_CNT_W = $clog2(HASH_STEPS);

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [SLOT_W-1:0]   t_slot;

    localparam t_op OP_PUT = 2'd0;
    localparam t_op OP_GET = 2'd1;
    localparam t_op OP_DEL = 2'd2;

    localparam t_slot SLOT_EMPTY = 2'd0;
    localparam t_slot SLOT_USED  = 2'd1;
    localparam t_slot SLOT_GONE  = 2'd2;

    localparam t_status ST_STORED    = 3'd0;
    localparam t_status ST_FOUND     = 3'd1;
    localparam t_status ST_DELETED   = 3'd2;
    localparam t_status ST_NOT_FOUND = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    typedef struct packed {
        logic clear_en;
        logic start;
        logic hash_en;
        logic probe_en;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic probe_done;
    } t_dp_sts;

endpackage

`default_nettype wire

### hdl/linear_probe_hash_map.sv
// Top level of the linear probing hash map: sequencer plus datapath.
// Depends on lphm_pkg, lphm_ctrl, lphm_dp (which holds two lphm_ram instances).
`timescale 1ns / 1ps
`default_nettype none

// Open-addressing hash map over N_SLOTS slots taking put, get and delete
// operations on 64-bit keys, one at a time, each answered with one result
// transfer. After reset the slot state memory is cleared one slot per cycle,
// and the input stalls until the clearing pass is over. Each item is then
// accepted; its key is reduced modulo N_SLOTS one 16-bit key digit at a time,
// each digit by a reciprocal multiply, then a multiply-subtract with one
// correction; the slots are probed at one slot per cycle through the read
// port of the slot memories (between 1 and N_SLOTS slots, a few at moderate
// load); and the result is handed to the output register once that register
// is free. A new item is taken while an earlier result still waits in the
// output register.
module linear_probe_hash_map #(
    parameter int N_SLOTS = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [lphm_pkg::OP_W-1:0]           i_op,
    input  wire logic [lphm_pkg::KEY_W-1:0]          i_key,
    input  wire logic signed [lphm_pkg::VAL_W-1:0]   i_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [lphm_pkg::STATUS_W-1:0]            o_status,
    output logic signed [lphm_pkg::VAL_W-1:0]        o_value_out
);

    import lphm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    lphm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    lphm_dp #(
        .N_SLOTS(N_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_status    (o_status),
        .o_value_out (o_value_out)
    );

endmodule

`default_nettype wire

### hdl/lphm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lphm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/lphm_ctrl.sv
// Sequencer of the hash map: clearing pass, key hashing, probing and result hand-off.
// Depends on lphm_pkg and assert_macros.svh; drives lphm_dp through a command struct.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lphm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output lphm_pkg::t_dp_cmd      o_cmd,
    input  wire lphm_pkg::t_dp_sts i_sts
);

    import lphm_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } t_state;

    localparam logic [HASH_CNT_W-1:0] HASH_LAST = HASH_CNT_W'(HASH_STEPS - 1);

    t_state                r_state, n_state;
    logic [HASH_CNT_W-1:0] r_hash_cnt, n_hash_cnt;
    logic                  r_out_valid, n_out_valid;
    logic                  out_free;

    // The output register may be reloaded in the cycle its transfer completes.
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_hash_cnt  = r_hash_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_hash_cnt  = '0;
                    n_state     = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_en = 1'b1;
                n_hash_cnt    = r_hash_cnt + 1'b1;
                if (r_hash_cnt == HASH_LAST) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                o_cmd.probe_en = 1'b1;
                if (i_sts.probe_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_hash_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hash_cnt  <= n_hash_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `LPHM_ASSERT_NEXT(a_accept_starts_hash, i_in_valid && !o_in_stall, (r_state == S_HASH) && (r_hash_cnt == '0), "accepted item did not start hashing")
    `LPHM_ASSERT_IMP(a_no_result_overwrite, o_cmd.load_out, !r_out_valid || !i_out_stall, "pending result overwritten")
    `LPHM_ASSERT_IMP(a_result_from_done, $rose(r_out_valid), $past(r_state) == S_DONE, "result raised outside the hand-off state")

endmodule

`default_nettype wire

### hdl/lphm_dp.sv
// Datapath of the hash map: item registers, home-slot remainder unit, probe logic,
// slot state and entry memories, result registers. Depends on lphm_pkg, lphm_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lphm_dp #(
    parameter int N_SLOTS = 1024
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lphm_pkg::t_dp_cmd                   i_cmd,
    output lphm_pkg::t_dp_sts                        o_sts,
    input  wire logic [lphm_pkg::OP_W-1:0]           i_op,
    input  wire logic [lphm_pkg::KEY_W-1:0]          i_key,
    input  wire logic signed [lphm_pkg::VAL_W-1:0]   i_value,
    output logic [lphm_pkg::STATUS_W-1:0]            o_status,
    output logic signed [lphm_pkg::VAL_W-1:0]        o_value_out
);

    import lphm_pkg::*;

    localparam int              IW      = $clog2(N_SLOTS);
    localparam int              ENT_W   = KEY_W + VAL_W;
    localparam logic [IW:0]     N_EXT   = (IW+1)'(N_SLOTS);
    localparam logic [IW-1:0]   MAX_IDX = IW'(N_SLOTS - 1);
    // floor(2^32 / N_SLOTS) gives a quotient estimate that is at most one short.
    localparam logic [63:0]     RECIP_W = 64'h1_0000_0000 / 64'(N_SLOTS);
    localparam logic [31:0]     RECIP   = RECIP_W[31:0];
    localparam logic [31:0]     N_32    = 32'(N_SLOTS);
    localparam logic [31:0]     N2_32   = 32'(2 * N_SLOTS);

    // Item registers
    t_op                r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_value;
    logic [KEY_W-1:0]   r_hkey;

    // Probe registers; r_idx also holds the running remainder while hashing.
    logic [IW-1:0]      r_idx, n_idx;
    logic [IW-1:0]      r_cnt;
    logic [IW-1:0]      r_clr;
    logic               r_have_free;
    logic [IW-1:0]      r_free_idx;

    logic               r_hphase;
    logic [DIGIT_W-1:0] r_hq;

    t_status            r_res_status, res_status;
    logic [VAL_W-1:0]   r_res_vout, res_vout;
    t_status            r_out_status;
    logic [VAL_W-1:0]   r_out_vout;

    logic [31:0]        hash_x;
    logic [63:0]        hash_prod;
    logic [31:0]        hash_qn;
    logic [31:0]        hash_est;
    logic [31:0]        hash_fix;
    logic [IW-1:0]      hash_rem;
    logic [IW-1:0]      next_idx;
    logic [IW:0]        idx_ext;

    t_slot              st_rd;
    logic [ENT_W-1:0]   ent_rd;
    logic [KEY_W-1:0]   key_rd;
    logic [VAL_W-1:0]   val_rd;

    logic               is_used, is_empty, match, last;
    logic               have_free_n;
    logic [IW-1:0]      free_idx_n;
    logic               done;

    logic               ent_we_p, st_we_p;
    logic [IW-1:0]      ent_waddr, st_waddr_p;
    t_slot              st_wdata_p;

    logic               ent_we, st_we;
    logic [IW-1:0]      st_waddr;
    t_slot              st_wdata;

    // Horner's rule over 16-bit key digits: rem = (rem * 2^16 + digit) mod N_SLOTS.
    // For each digit, a reciprocal multiply first estimates the quotient; then the
    // quotient times N_SLOTS is subtracted and the remainder is corrected once.
    assign hash_x    = 32'({r_idx, r_hkey[KEY_W-1 -: DIGIT_W]});
    assign hash_prod = 64'(hash_x) * 64'(RECIP);
    assign hash_qn   = 32'(r_hq) * N_32;
    assign hash_est  = hash_x - hash_qn;
    assign hash_fix  = (hash_est >= N_32) ? hash_est - N_32 : hash_est;
    assign hash_rem  = hash_fix[IW-1:0];

    assign next_idx = (r_idx == MAX_IDX) ? '0 : r_idx + 1'b1;
    assign idx_ext  = {1'b0, r_idx};

    assign key_rd = ent_rd[ENT_W-1:VAL_W];
    assign val_rd = ent_rd[VAL_W-1:0];

    assign is_used     = (st_rd == SLOT_USED);
    assign is_empty    = (st_rd == SLOT_EMPTY);
    assign match       = is_used && (key_rd == r_key);
    assign last        = (r_cnt == MAX_IDX);
    assign have_free_n = r_have_free || !is_used;
    assign free_idx_n  = r_have_free ? r_free_idx : r_idx;

    // Evaluation of the slot whose read data is present this cycle.
    always_comb begin
        done       = 1'b0;
        res_status = ST_NOT_FOUND;
        res_vout   = '0;
        ent_we_p   = 1'b0;
        ent_waddr  = r_idx;
        st_we_p    = 1'b0;
        st_waddr_p = r_idx;
        st_wdata_p = SLOT_USED;
        unique case (r_op)
            OP_PUT: begin
                if (match) begin
                    done       = 1'b1;
                    res_status = ST_STORED;
                    ent_we_p   = 1'b1;
                end else if (is_empty || last) begin
                    done = 1'b1;
                    if (have_free_n) begin
                        res_status = ST_STORED;
                        ent_we_p   = 1'b1;
                        ent_waddr  = free_idx_n;
                        st_we_p    = 1'b1;
                        st_waddr_p = free_idx_n;
                    end else begin
                        res_status = ST_FULL;
                    end
                end
            end
            OP_GET: begin
                if (match) begin
                    done       = 1'b1;
                    res_status = ST_FOUND;
                    res_vout   = val_rd;
                end else if (is_empty || last) begin
                    done = 1'b1;
                end
            end
            OP_DEL: begin
                if (match) begin
                    done       = 1'b1;
                    res_status = ST_DELETED;
                    st_we_p    = 1'b1;
                    st_wdata_p = SLOT_GONE;
                end else if (is_empty || last) begin
                    done = 1'b1;
                end
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    // The read address is the next probe index, so the read data for r_idx arrives while r_idx holds it.
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.start) begin
            n_idx = '0;
        end else if (i_cmd.hash_en && r_hphase) begin
            n_idx = hash_rem;
        end else if (i_cmd.probe_en && !done) begin
            n_idx = next_idx;
        end
    end

    assign ent_we   = i_cmd.probe_en && ent_we_p;
    assign st_we    = i_cmd.clear_en || (i_cmd.probe_en && st_we_p);
    assign st_waddr = i_cmd.clear_en ? r_clr : st_waddr_p;
    assign st_wdata = i_cmd.clear_en ? SLOT_EMPTY : st_wdata_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_en && (r_clr != MAX_IDX)) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.start) begin
            r_op        <= i_op;
            r_key       <= i_key;
            r_value     <= i_value;
            r_hkey      <= i_key;
            r_hphase    <= 1'b0;
            r_cnt       <= '0;
            r_have_free <= 1'b0;
            r_free_idx  <= '0;
        end
        if (i_cmd.hash_en) begin
            r_hphase <= !r_hphase;
            if (r_hphase) begin
                r_hkey <= {r_hkey[KEY_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            end else begin
                r_hq <= hash_prod[32 +: DIGIT_W];
            end
        end
        if (i_cmd.probe_en) begin
            r_have_free <= have_free_n;
            r_free_idx  <= free_idx_n;
            if (done) begin
                r_res_status <= res_status;
                r_res_vout   <= res_vout;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_vout   <= r_res_vout;
        end
    end

    lphm_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(N_SLOTS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (n_idx),
        .o_rdata (st_rd)
    );

    lphm_ram #(
        .WIDTH(ENT_W),
        .DEPTH(N_SLOTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata ({r_key, r_value}),
        .i_raddr (n_idx),
        .o_rdata (ent_rd)
    );

    assign o_sts.clear_last = (r_clr == MAX_IDX);
    assign o_sts.probe_done = done;
    assign o_status         = r_out_status;
    assign o_value_out      = r_out_vout;

    `LPHM_ASSERT_IMP(a_probe_bounded, i_cmd.probe_en && last, done, "probe ran past the table size")
    `LPHM_ASSERT_NEXT(a_remainder_in_range, i_cmd.hash_en, idx_ext < N_EXT, "home slot remainder out of range")
    `LPHM_ASSERT_IMP(a_one_correction, i_cmd.hash_en && r_hphase, hash_est < N2_32, "quotient estimate more than one short")

endmodule

`default_nettype wire

### dv/linear_probe_hash_map_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for linear_probe_hash_map: a scoreboard class mirrors the slot table
// and checks each result transfer in order. It depends on lphm_pkg and the block's RTL only.

module linear_probe_hash_map_test;
    import lphm_pkg::*;

    localparam int N_SLOTS     = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 1100;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT     = 300;
    localparam int IDLE_PCT    = 19;
    localparam t_op OP_SPARE   = 2'd3;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] value;
    } t_lookup;

    class map_scoreboard;
        logic [63:0] slot_key [N_SLOTS];
        logic [31:0] slot_val [N_SLOTS];
        t_slot       slot_st  [N_SLOTS];
        t_lookup     awaited[$];
        int          errors;

        function new();
            foreach (slot_st[i]) slot_st[i] = SLOT_EMPTY;
            errors = 0;
        endfunction

        function int home_of(logic [63:0] key);
            return int'(key % N_SLOTS);
        endfunction

        function int step_on(int idx);
            return (idx + 1 >= N_SLOTS) ? 0 : idx + 1;
        endfunction

        // Lookup walk shared by get and delete: tombstones are passed over.
        function bit locate(logic [63:0] key, output int where);
            int idx;
            idx = home_of(key);
            where = 0;
            for (int n = 0; n < N_SLOTS; n++) begin
                if (slot_st[idx] == SLOT_EMPTY) return 1'b0;
                if (slot_st[idx] == SLOT_USED && slot_key[idx] == key) begin
                    where = idx;
                    return 1'b1;
                end
                idx = step_on(idx);
            end
            return 1'b0;
        endfunction

        function t_status insert(logic [63:0] key, logic [31:0] val);
            int idx;
            int free_idx;
            bit have_free;
            idx = home_of(key);
            free_idx = 0;
            have_free = 1'b0;
            for (int n = 0; n < N_SLOTS; n++) begin
                if (slot_st[idx] == SLOT_USED) begin
                    if (slot_key[idx] == key) begin
                        slot_val[idx] = val;
                        return ST_STORED;
                    end
                end else begin
                    if (!have_free) begin
                        have_free = 1'b1;
                        free_idx = idx;
                    end
                    if (slot_st[idx] == SLOT_EMPTY) break;
                end
                idx = step_on(idx);
            end
            if (!have_free) return ST_FULL;
            slot_key[free_idx] = key;
            slot_val[free_idx] = val;
            slot_st[free_idx] = SLOT_USED;
            return ST_STORED;
        endfunction

        function void note_input(t_op op, logic [63:0] key, logic [31:0] val);
            t_lookup r;
            int where;
            r.status = ST_NOT_FOUND;
            r.value = '0;
            case (op)
                OP_PUT: r.status = insert(key, val);
                OP_GET: begin
                    if (locate(key, where)) begin
                        r.status = ST_FOUND;
                        r.value = slot_val[where];
                    end
                end
                OP_DEL: begin
                    if (locate(key, where)) begin
                        slot_st[where] = SLOT_GONE;
                        r.status = ST_DELETED;
                    end
                end
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_result(t_status status, logic signed [31:0] value);
            t_lookup r;
            if (awaited.size() == 0) begin
                report($sformatf("result status %0d with no outstanding operation", status));
                return;
            end
            r = awaited.pop_front();
            if (status !== r.status)
                report($sformatf("status %0d, wanted %0d", status, r.status));
            if (value !== r.value)
                report($sformatf("value_out %0d, wanted %0d", value, r.value));
        endtask

        task check_drained();
            if (awaited.size() != 0)
                report($sformatf("%0d results never arrived", awaited.size()));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_op                 i_op;
    logic [63:0]         i_key;
    logic signed [31:0]  i_value;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [2:0]          o_status;
    logic signed [31:0]  o_value_out;

    map_scoreboard sb;
    bit            steady;
    int            results_seen;
    int            quiet_cycles;
    logic [63:0]   pool[$];
    logic [63:0]   fill_keys[$];

    linear_probe_hash_map #(.N_SLOTS(N_SLOTS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_value_out (o_value_out)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Offers one operation and returns once it has been taken by the block.
    task send_op(t_op op, logic [63:0] key, logic [31:0] val);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_key <= key;
        i_value <= val;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(op, key, val);
    endtask

    function t_op pick_op(int put_pct, int get_pct, int del_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < put_pct) return OP_PUT;
        if (r < put_pct + get_pct) return OP_GET;
        if (r < put_pct + get_pct + del_pct) return OP_DEL;
        return OP_SPARE;
    endfunction

    task run_directed();
        logic [63:0] wrap_key;
        wrap_key = 64'h8000_0000_0000_03FF;
        send_op(OP_GET, 64'd0, 32'd0);
        send_op(OP_PUT, 64'd0, 32'h7FFF_FFFF);
        send_op(OP_GET, 64'd0, 32'd0);
        send_op(OP_PUT, '1, 32'h8000_0000);
        send_op(OP_GET, '1, 32'hFFFF_FFFF);
        send_op(OP_PUT, 64'd1024, 32'hFFFF_FFFF);
        // Shares the last home slot with the all-ones key, so it wraps past slots 0 and 1
        // into slot 2.
        send_op(OP_PUT, wrap_key, 32'd0);
        send_op(OP_GET, 64'd1024, 32'd0);
        send_op(OP_GET, wrap_key, 32'd0);
        send_op(OP_DEL, 64'd0, 32'd0);
        send_op(OP_GET, 64'd0, 32'd0);
        send_op(OP_GET, 64'd1024, 32'd0);
        send_op(OP_DEL, 64'd0, 32'd0);
        send_op(OP_PUT, 64'd2048, 32'd12345);
        send_op(OP_GET, 64'd2048, 32'd0);
        send_op(OP_PUT, 64'd1024, 32'd77);
        send_op(OP_GET, 64'd1024, 32'd0);
        send_op(OP_SPARE, 64'd1024, -32'sd5);
        send_op(OP_DEL, '1, 32'd0);
        send_op(OP_GET, wrap_key, 32'd0);
        send_op(OP_PUT, wrap_key, 32'd5);
        send_op(OP_GET, wrap_key, 32'd0);
        send_op(OP_DEL, 64'd5, 32'd0);
    endtask

    // Keys are crowded into a few home slots either side of the wrap point so that
    // probe chains, tombstones and wrap-around all come up often.
    task run_churn(int count);
        logic [63:0] key;
        pool.push_back(64'd0);
        pool.push_back('1);
        for (int j = 0; j < 40; j++) begin
            key = {$urandom, $urandom};
            key[9:0] = (j % 3 == 0) ? 10'(1016 + $urandom_range(0, 7)) : 10'($urandom_range(0, 15));
            pool.push_back(key);
        end
        for (int n = 0; n < count; n++) begin
            steady = (n >= 100 && n < 250);
            if ($urandom_range(0, 19) == 0) key = {$urandom, $urandom};
            else key = pool[$urandom_range(0, pool.size() - 1)];
            send_op(pick_op(40, 30, 25), key, $urandom);
        end
        steady = 1'b0;
    endtask

    // As many new keys as slots: the table fills and the last puts meet a full table.
    task fill_table();
        logic [63:0] key;
        for (int i = 0; i < N_SLOTS; i++) begin
            key = {$urandom, $urandom};
            key[9:0] = 10'(i);
            fill_keys.push_back(key);
            send_op(OP_PUT, key, $urandom);
        end
    endtask

    task run_full_mix(int count);
        logic [63:0] known;
        int r;
        for (int n = 0; n < count; n++) begin
            known = fill_keys[$urandom_range(0, fill_keys.size() - 1)];
            r = $urandom_range(0, 99);
            if (r < 35) send_op(OP_GET, known, $urandom);
            else if (r < 55) send_op(OP_PUT, known, $urandom);
            else if (r < 70) send_op(OP_DEL, known, $urandom);
            else if (r < 85) send_op(OP_PUT, {$urandom, $urandom}, $urandom);
            else if (r < 95) send_op(OP_GET, {$urandom, $urandom}, $urandom);
            else send_op(OP_SPARE, known, $urandom);
        end
    endtask

    initial begin
        sb = new();
        steady = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_PUT;
        i_key = '0;
        i_value = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_churn(520);
        fill_table();
        run_full_mix(90);
        i_in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off that lets the block fill up.
    initial begin
        bit held;
        held = 1'b0;
        results_seen = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                sb.check_result(t_status'(o_status), o_value_out);
                results_seen++;
            end
            if (!held && results_seen == HOLD_AT) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

### linear_probe_hash_map.f
+incdir+hdl
hdl/lphm_pkg.sv
hdl/lphm_ram.sv
hdl/lphm_ctrl.sv
hdl/lphm_dp.sv
hdl/linear_probe_hash_map.sv
dv/linear_probe_hash_map_test.sv
